@@ sv/multi_sender_packet_deframer_macros.svh @@
// Assertion macros shared by the deframer modules.
`ifndef MULTI_SENDER_PACKET_DEFRAMER_MACROS_SVH
`define MULTI_SENDER_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define MSPD_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, sampled on clock, quiet during reset.
`define MSPD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

@@ sv/mspd_pkg.sv @@
// Shared constants, types and codes of the multi-sender packet deframer.
package mspd_pkg;

   localparam int SENDERS     = 64;
   localparam int SND_W       = $clog2(SENDERS);
   localparam int SLOTS       = 64;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int MAX_PAYLOAD = 32;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD);
   localparam int LEN_W       = 6;
   localparam int STORE_DEPTH = SENDERS * MAX_PAYLOAD;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int JOBQ_DEPTH  = 2;
   localparam int CSR_IDX_W   = 2;

   localparam logic        ACT_DEFINE   = 1'b0;
   localparam logic        ACT_BYTE     = 1'b1;
   localparam logic        KIND_STATUS  = 1'b0;
   localparam logic        KIND_PAYLOAD = 1'b1;
   localparam logic [1:0]  ST_OK        = 2'd0;
   localparam logic [1:0]  ST_IN_USE    = 2'd1;
   localparam logic [1:0]  ST_SIZE      = 2'd2;
   localparam logic [1:0]  PH_HUNT      = 2'd0;
   localparam logic [1:0]  PH_IDENT     = 2'd1;
   localparam logic [1:0]  PH_DATA      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAY  = 2'd1;

   typedef struct packed {
      logic             kind;
      logic [1:0]       status;
      logic [SND_W-1:0] snd;
      logic [7:0]       ident;
      logic [LEN_W-1:0] len;
   } job_type;

   typedef struct packed {
      logic [1:0]       phase;
      logic [7:0]       ident;
      logic [LEN_W-1:0] count;
      logic [LEN_W-1:0] size;
   } snd_ent_type;

   typedef struct packed {
      logic [7:0]       ident;
      logic [LEN_W-1:0] size;
   } slot_ent_type;

   typedef struct packed {
      logic pay_done;
   } back_stat_type;

   typedef enum logic {F_IDLE, F_EXEC} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_READ, B_WAIT, B_HOLD} back_state_type;

endpackage

@@ sv/mspd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mspd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ sv/mspd_front.sv @@
// Front end: accepts items, keeps definitions and per-sender hunt state.
module mspd_front import mspd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                req_action,
   input  logic [SND_W-1:0]    req_sender,
   input  logic [7:0]          req_value,
   input  logic [7:0]          req_define_size,
   input  logic [7:0]          preamble,
   input  logic [LEN_W-1:0]    max_pay,
   input  logic                q_full,
   output logic                q_push,
   output job_type             q_job,
   input  back_stat_type       back_stat,
   output logic                store_we,
   output logic [STORE_AW-1:0] store_waddr,
   output logic [7:0]          store_wdata
);
   front_state_type state_ff, state_in;
   logic              act_ff;
   logic [SND_W-1:0]  snd_ff;
   logic [7:0]        val_ff, dsz_ff;
   logic [SLOTS-1:0]  slot_vld_ff, slot_vld_in;
   logic [SENDERS-1:0] snd_vld_ff, snd_vld_in;
   logic              pay_ff, pay_in;
   logic              accept;
   logic              slot_we, snd_we;
   slot_ent_type      slot_rd, slot_wr;
   snd_ent_type       snd_rd, snd_wr, cur;
   logic [SLOT_W-1:0] slot_idx;
   logic [LEN_W-1:0]  cnt_nx;
   logic              size_bad;

   assign full   = (state_ff != F_IDLE) || q_full || pay_ff;
   assign accept = push && !full;

   mspd_ram #(.WIDTH($bits(slot_ent_type)), .DEPTH(SLOTS)) u_slot_ram (
      .clock(clock), .we(slot_we), .waddr(slot_idx), .wdata(slot_wr),
      .raddr(req_value[SLOT_W-1:0]), .rdata(slot_rd)
   );

   mspd_ram #(.WIDTH($bits(snd_ent_type)), .DEPTH(SENDERS)) u_snd_ram (
      .clock(clock), .we(snd_we), .waddr(snd_ff), .wdata(snd_wr),
      .raddr(req_sender), .rdata(snd_rd)
   );

   always_comb begin
      unique case (state_ff)
         F_IDLE:  state_in = accept ? F_EXEC : F_IDLE;
         F_EXEC:  state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   assign slot_idx = val_ff[SLOT_W-1:0];
   assign cur      = snd_vld_ff[snd_ff] ? snd_rd : '0;
   assign cnt_nx   = cur.count + LEN_W'(1);
   assign size_bad = (dsz_ff == 8'd0) || (dsz_ff > {2'b00, max_pay})
                     || (dsz_ff > 8'(MAX_PAYLOAD));

   always_comb begin
      slot_we     = 1'b0;
      slot_wr     = '{ident: val_ff, size: dsz_ff[LEN_W-1:0]};
      slot_vld_in = slot_vld_ff;
      snd_we      = 1'b0;
      snd_wr      = cur;
      snd_vld_in  = snd_vld_ff;
      q_push      = 1'b0;
      q_job       = '{kind: KIND_STATUS, status: ST_OK, snd: '0, ident: val_ff,
                      len: LEN_W'(1)};
      store_we    = 1'b0;
      store_waddr = {snd_ff, cur.count[CNT_W-1:0]};
      store_wdata = val_ff;
      pay_in      = pay_ff && !back_stat.pay_done;
      if (state_ff == F_EXEC) begin
         if (act_ff == ACT_DEFINE) begin
            q_push = 1'b1;
            priority if (slot_vld_ff[slot_idx]) begin
               q_job.status = ST_IN_USE;
            end else if (size_bad) begin
               q_job.status = ST_SIZE;
            end else begin
               slot_we               = 1'b1;
               slot_vld_in[slot_idx] = 1'b1;
            end
         end else begin
            unique case (cur.phase)
               PH_IDENT: begin
                  if (slot_vld_ff[slot_idx] && (slot_rd.ident == val_ff)) begin
                     snd_we       = 1'b1;
                     snd_wr.phase = PH_DATA;
                     snd_wr.ident = val_ff;
                     snd_wr.count = '0;
                     snd_wr.size  = slot_rd.size;
                  end
               end
               PH_DATA: begin
                  store_we = 1'b1;
                  snd_we   = 1'b1;
                  if (cnt_nx < cur.size) begin
                     snd_wr.count = cnt_nx;
                  end else begin
                     snd_wr.count = '0;
                     snd_wr.phase = PH_HUNT;
                     q_push       = 1'b1;
                     q_job        = '{kind: KIND_PAYLOAD, status: ST_OK, snd: snd_ff,
                                      ident: cur.ident, len: cnt_nx};
                     pay_in       = 1'b1;
                  end
               end
               default: begin
                  // hunting the preamble; phase 3 counts as hunting too
                  if (val_ff == preamble) begin
                     snd_we       = 1'b1;
                     snd_wr.phase = PH_IDENT;
                  end
               end
            endcase
            if (snd_we) begin
               snd_vld_in[snd_ff] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         slot_vld_ff <= '0;
         snd_vld_ff  <= '0;
         pay_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         slot_vld_ff <= slot_vld_in;
         snd_vld_ff  <= snd_vld_in;
         pay_ff      <= pay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         snd_ff <= req_sender;
         val_ff <= req_value;
         dsz_ff <= req_define_size;
      end
   end
endmodule

@@ sv/mspd_jobq.sv @@
// Short job queue between the front end and the result sequencer.
module mspd_jobq import mspd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_job
);
   localparam int PW = $clog2(JOBQ_DEPTH);
   job_type         ent_ff [JOBQ_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]     cnt_ff, cnt_in;

   assign full    = (cnt_ff == (PW+1)'(JOBQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_job = ent_ff[rp_ff];

   always_comb begin
      wp_in  = (push && !full) ? wp_ff + PW'(1) : wp_ff;
      rp_in  = (pop && !empty) ? rp_ff + PW'(1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         ent_ff[wp_ff] <= push_job;
      end
   end

`include "multi_sender_packet_deframer_macros.svh"
   `MSPD_ASSERT_IMPL(a_no_overflow, push, !full)
   `MSPD_ASSERT_NEXT(a_cnt_move, push && !full && !(pop && !empty), !empty)
endmodule

@@ sv/mspd_back.sv @@
// Result sequencer: turns queued jobs into status or payload transfers.
module mspd_back import mspd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  job_type             q_job,
   output logic                q_pop,
   output logic [STORE_AW-1:0] store_raddr,
   input  logic [7:0]          store_rdata,
   output back_stat_type       back_stat,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_kind,
   output logic [1:0]          rsp_status,
   output logic [SND_W-1:0]    rsp_out_sender,
   output logic [7:0]          rsp_packet_ident,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_last
);
   back_state_type   state_ff, state_in;
   job_type          job_ff;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             take, done, more;

   assign take        = (state_ff == B_IDLE) && !q_empty;
   assign done        = (state_ff == B_HOLD) && pop;
   assign more        = (job_ff.kind == KIND_PAYLOAD) && ((k_ff + LEN_W'(1)) < job_ff.len);
   assign store_raddr = {job_ff.snd, k_ff[CNT_W-1:0]};

   always_comb begin
      unique case (state_ff)
         B_IDLE:  state_in = !take ? B_IDLE
                             : (q_job.kind == KIND_PAYLOAD) ? B_READ : B_HOLD;
         B_READ:  state_in = B_WAIT;
         B_WAIT:  state_in = B_HOLD;
         B_HOLD:  state_in = !done ? B_HOLD : more ? B_READ : B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop              = take;
      back_stat.pay_done = done && !more && (job_ff.kind == KIND_PAYLOAD);
      k_in               = k_ff;
      byte_in            = byte_ff;
      last_in            = last_ff;
      if (take) begin
         k_in    = '0;
         byte_in = '0;
         last_in = 1'b0;
      end else if (state_ff == B_WAIT) begin
         byte_in = store_rdata;
         last_in = ((k_ff + LEN_W'(1)) == job_ff.len);
      end else if (done && more) begin
         k_in = k_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= q_job;
      end
      k_ff    <= k_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign empty            = (state_ff != B_HOLD);
   assign rsp_kind         = job_ff.kind;
   assign rsp_status       = job_ff.status;
   assign rsp_out_sender   = job_ff.snd;
   assign rsp_packet_ident = job_ff.ident;
   assign rsp_payload_byte = byte_ff;
   assign rsp_last         = last_ff;

`include "multi_sender_packet_deframer_macros.svh"
   `MSPD_ASSERT_IMPL(a_len_nz, take && (q_job.kind == KIND_PAYLOAD), q_job.len != '0)
   `MSPD_ASSERT_IMPL(a_k_bound, (state_ff != B_IDLE) && (job_ff.kind == KIND_PAYLOAD),
                     k_ff < job_ff.len)
   `MSPD_ASSERT_NEXT(a_last_idle, pop && !empty && rsp_last, state_ff == B_IDLE)
endmodule

@@ sv/multi_sender_packet_deframer.sv @@
// Top level of the multi-sender packet deframer.
//
// Input queue (push/full): action 0 defines a packet identifier with its
// payload size; action 1 delivers one received byte for one sender. Each
// sender hunts for the preamble, then for a defined identifier, then collects
// that many payload bytes. A definition yields one status transfer; a
// finished packet yields its payload as a run of transfers, last set on the
// final byte. Result queue (empty/pop) shows the oldest transfer.
// CSR channel (valid/ready, always ready): index 0 preamble, 1 max size.
// An item is taken in one cycle and executed in the next; the front end takes
// no new item while one executes, set by the read-then-write of the definition
// and sender context RAMs. A status is queued for the sequencer.
// Payload bytes pass the read, wait and hold states (reassembly RAM address,
// read data, output register); input holds off while a packet payload is sent.
// Reset clears all definitions and sender contexts at once via valid bits;
// no clearing pass. A stalled receiver backs up the two-entry job queue and
// then holds full high; nothing is dropped.
module multi_sender_packet_deframer import mspd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_action,
   input  logic [SND_W-1:0]     req_sender,
   input  logic [7:0]           req_value,
   input  logic [7:0]           req_define_size,
   output logic                 empty,
   input  logic                 pop,
   output logic                 rsp_kind,
   output logic [1:0]           rsp_status,
   output logic [SND_W-1:0]     rsp_out_sender,
   output logic [7:0]           rsp_packet_ident,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_last,
   input  logic                 valid,
   output logic                 ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);
   logic [7:0]          preamble_ff;
   logic [LEN_W-1:0]    max_pay_ff;
   logic                q_push, q_full, q_pop, q_empty;
   job_type             push_job, pop_job;
   back_stat_type       back_stat;
   logic                store_we;
   logic [STORE_AW-1:0] store_waddr, store_raddr;
   logic [7:0]          store_wdata, store_rdata;

   // config writes are always taken
   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= 8'd170;
         max_pay_ff  <= LEN_W'(MAX_PAYLOAD);
      end else if (valid && ready) begin
         unique case (csr_index)
            CSR_PREAMBLE: preamble_ff <= csr_data;
            CSR_MAX_PAY:  max_pay_ff  <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   mspd_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_action(req_action), .req_sender(req_sender), .req_value(req_value),
      .req_define_size(req_define_size), .preamble(preamble_ff), .max_pay(max_pay_ff),
      .q_full(q_full), .q_push(q_push), .q_job(push_job), .back_stat(back_stat),
      .store_we(store_we), .store_waddr(store_waddr), .store_wdata(store_wdata)
   );

   mspd_jobq u_jobq (
      .clock(clock), .reset(reset), .push(q_push), .push_job(push_job), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_job(pop_job)
   );

   // per-sender payload bytes, sender number picks the row
   mspd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .we(store_we), .waddr(store_waddr), .wdata(store_wdata),
      .raddr(store_raddr), .rdata(store_rdata)
   );

   mspd_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_job(pop_job), .q_pop(q_pop),
      .store_raddr(store_raddr), .store_rdata(store_rdata), .back_stat(back_stat),
      .empty(empty), .pop(pop), .rsp_kind(rsp_kind), .rsp_status(rsp_status),
      .rsp_out_sender(rsp_out_sender), .rsp_packet_ident(rsp_packet_ident),
      .rsp_payload_byte(rsp_payload_byte), .rsp_last(rsp_last)
   );
endmodule
